// File: src/dssp_pkg.sv
// types, codes and helper functions of the delta snapshot stream parser
// used by dssp_res_queue and delta_snapshot_stream_parser; no dependencies
package dssp_pkg;

  localparam int unsigned ID_BYTES_DEFAULT = 8;
  localparam int unsigned RES_QUEUE_DEPTH  = 4;
  localparam int unsigned CFG_IDX_W        = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOMBSTONE_COUNT  = 1'd1;

  // result kinds
  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_ENTITY    = 3'd1;
  localparam logic [2:0] KIND_TOMBSTONE = 3'd2;
  localparam logic [2:0] KIND_COMP_HDR  = 3'd3;
  localparam logic [2:0] KIND_DATA      = 3'd4;
  localparam logic [2:0] KIND_OK        = 3'd5;
  localparam logic [2:0] KIND_ERROR     = 3'd6;

  // error codes
  localparam logic [2:0] ERR_SHORT_HEADER = 3'd0;
  localparam logic [2:0] ERR_VERSION      = 3'd1;
  localparam logic [2:0] ERR_ID           = 3'd2;
  localparam logic [2:0] ERR_COUNT        = 3'd3;
  localparam logic [2:0] ERR_COMP_HDR     = 3'd4;
  localparam logic [2:0] ERR_DATA         = 3'd5;

  typedef enum logic [3:0] {
    PH_HDR0  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_HDR2  = 4'd2,
    PH_HDR3  = 4'd3,
    PH_HDR4  = 4'd4,
    PH_HDR5  = 4'd5,
    PH_ID    = 4'd6,
    PH_COUNT = 4'd7,
    PH_TYPE  = 4'd8,
    PH_LEN   = 4'd9,
    PH_DATA  = 4'd10,
    PH_SKIP  = 4'd11
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  header_field;
    logic [15:0] type_id;
    logic [15:0] length;
    logic [2:0]  error_code;
    logic        last_of_step;
  } res_item_t;

  // results of one accepted byte, at most two
  typedef struct packed {
    logic [1:0] count;
    res_item_t  r0;
    res_item_t  r1;
  } res_pair_t;

  // bytes in each header field
  function automatic logic [3:0] hdr_size(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0:    s = 4'd4;
      3'd1:    s = 4'd8;
      3'd2:    s = 4'd8;
      3'd3:    s = 4'd8;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd4;
      default: s = 4'd4;
    endcase
    return s;
  endfunction

  function automatic res_item_t mk_res(input logic [2:0]  kind,
                                       input logic [63:0] value,
                                       input logic [2:0]  hf,
                                       input logic [15:0] type_id,
                                       input logic [15:0] length,
                                       input logic [2:0]  err);
    res_item_t r;
    r.kind         = kind;
    r.value        = value;
    r.header_field = hf;
    r.type_id      = type_id;
    r.length       = length;
    r.error_code   = err;
    r.last_of_step = 1'b0;
    return r;
  endfunction

endpackage

// File: src/dssp_res_queue.sv
// result queue of the snapshot parser: takes up to two results a cycle,
// hands out one a cycle over valid/ready; depends on dssp_pkg
module dssp_res_queue #(
  parameter int unsigned DEPTH = dssp_pkg::RES_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dssp_pkg::res_pair_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dssp_pkg::res_item_t  out_data_o
);
  import dssp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  res_item_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d, wr1, wr2;
  logic [LW-1:0]     level_q, level_d;
  logic              pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr1 = wrap_inc(wr_q);
  assign wr2 = wrap_inc(wr1);

  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two results from the next item
  assign room_o      = (level_q <= LW'(DEPTH - 2));

  always_comb begin
    case (push_i.count)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = wr2;
      default: wr_d = wr_q;
    endcase
    rd_d    = pop ? wrap_inc(rd_q) : rd_q;
    level_d = level_q + LW'(push_i.count) - LW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr1] <= push_i.r1;
    end
  end

endmodule

// File: src/delta_snapshot_stream_parser.sv
// top level of the delta snapshot stream parser: byte parser state and step logic
// depends on dssp_pkg and dssp_res_queue
//
// Takes one snapshot byte per cycle and writes the results that the byte causes
// (none, one or two) into a four-entry result queue, which hands out one result
// per cycle while out_ready_i is high. A byte is taken whenever the queue holds
// two results or fewer, so bytes that cause at most one result each stream at
// one per cycle; each byte that causes two results (a header field, entity,
// tombstone, component header or data byte followed by ok or an error) fills
// two queue entries. The header is
// little endian: version 4 bytes, tick, sequence and ack 8 each, entity count
// and payload size 4 each; entity ids are ENTITY_ID_BYTES bytes. Bytes after
// ok or an error give no result until the packet's last byte. Configuration
// writes are to be made only while the block is idle.
module delta_snapshot_stream_parser #(
  parameter int unsigned ENTITY_ID_BYTES = dssp_pkg::ID_BYTES_DEFAULT,
  parameter int unsigned RES_DEPTH       = dssp_pkg::RES_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dssp_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dssp_pkg::res_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dssp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import dssp_pkg::*;

  logic [31:0] exp_ver_q;
  logic [15:0] tomb_q;

  phase_e      ph_q, ph_d, ph;
  logic [3:0]  bif_q, bif_d;
  logic [63:0] asm_q, asm_d;
  logic [31:0] ent_q, ent_d;
  logic [15:0] comp_q, comp_d;
  logic [15:0] dl_q, dl_d;
  logic [15:0] held_q, held_d;

  logic        accept;
  res_pair_t   push;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    res_item_t   res [2];
    logic [1:0]  n;
    logic [7:0]  b;
    logic [63:0] asm_acc;
    logic [3:0]  bif_inc;
    logic [15:0] held_new;
    logic        fin_comp;
    logic        fin_ent;
    logic [2:0]  code;

    b        = in_data_i.data_byte;
    asm_acc  = asm_q | ({56'd0, b} << {bif_q[2:0], 3'b000});
    bif_inc  = bif_q + 4'd1;
    held_new = (bif_q != 4'd0) ? (held_q | {b, 8'd0}) : {8'd0, b};
    res[0]   = '0;
    res[1]   = '0;
    n        = 2'd0;
    fin_comp = 1'b0;
    fin_ent  = 1'b0;
    code     = ERR_SHORT_HEADER;

    ph     = (ph_q > PH_SKIP) ? PH_SKIP : ph_q;
    ph_d   = ph;
    bif_d  = bif_q;
    asm_d  = asm_q;
    ent_d  = ent_q;
    comp_d = comp_q;
    dl_d   = dl_q;
    held_d = held_q;

    if (ph < PH_ID) begin
      asm_d = asm_acc;
      bif_d = bif_inc;
      if (bif_inc >= hdr_size(ph[2:0])) begin
        res[n[0]] = mk_res(KIND_HEADER, asm_acc, ph[2:0], '0, '0, '0);
        n = n + 2'd1;
        bif_d = '0;
        asm_d = '0;
        ph_d  = phase_e'(ph + 4'd1);
        if (ph == PH_HDR0) begin
          // version mismatch flag lives in data_left during the header
          dl_d = {15'd0, asm_acc[31:0] != exp_ver_q};
        end
        if (ph == PH_HDR4) begin
          ent_d = asm_acc[31:0];
        end
        if (ph == PH_HDR5) begin
          if (dl_q != 16'd0) begin
            res[n[0]] = mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_VERSION);
            n = n + 2'd1;
            ph_d  = PH_SKIP;
            bif_d = bif_inc;
            asm_d = asm_acc;
          end else if (ent_q == 32'd0) begin
            res[n[0]] = mk_res(KIND_OK, '0, '0, '0, '0, '0);
            n = n + 2'd1;
            ph_d  = PH_SKIP;
            bif_d = bif_inc;
            asm_d = asm_acc;
          end else begin
            dl_d = '0;
            ph_d = PH_ID;
          end
        end
      end
    end else begin
      case (ph)
        PH_ID: begin
          asm_d = asm_acc;
          bif_d = bif_inc;
          if (bif_inc >= 4'(ENTITY_ID_BYTES)) begin
            ph_d   = PH_COUNT;
            bif_d  = '0;
            held_d = '0;
          end
        end
        PH_COUNT: begin
          held_d = held_new;
          bif_d  = bif_inc;
          if (bif_inc >= 4'd2) begin
            if (held_new == tomb_q) begin
              res[n[0]] = mk_res(KIND_TOMBSTONE, asm_q, '0, '0, held_new, '0);
              n = n + 2'd1;
              fin_ent = 1'b1;
            end else begin
              res[n[0]] = mk_res(KIND_ENTITY, asm_q, '0, '0, held_new, '0);
              n = n + 2'd1;
              comp_d = held_new;
              if (held_new == 16'd0) begin
                fin_ent = 1'b1;
              end else begin
                ph_d  = PH_TYPE;
                bif_d = '0;
                asm_d = '0;
              end
            end
          end
        end
        PH_TYPE: begin
          asm_d = asm_acc;
          bif_d = bif_inc;
          if (bif_inc >= 4'd2) begin
            held_d = asm_acc[15:0];
            ph_d   = PH_LEN;
            bif_d  = '0;
            asm_d  = '0;
          end
        end
        PH_LEN: begin
          asm_d = asm_acc;
          bif_d = bif_inc;
          if (bif_inc >= 4'd2) begin
            dl_d = asm_acc[15:0];
            res[n[0]] = mk_res(KIND_COMP_HDR, '0, '0, held_q, asm_acc[15:0], '0);
            n = n + 2'd1;
            if (asm_acc[15:0] == 16'd0) begin
              fin_comp = 1'b1;
            end else begin
              ph_d  = PH_DATA;
              bif_d = '0;
              asm_d = '0;
            end
          end
        end
        PH_DATA: begin
          res[n[0]] = mk_res(KIND_DATA, {56'd0, b}, '0, '0, '0, '0);
          n = n + 2'd1;
          dl_d = dl_q - 16'd1;
          if (dl_d == 16'd0) begin
            fin_comp = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (fin_comp) begin
      comp_d = comp_q - 16'd1;
      if (comp_d == 16'd0) begin
        fin_ent = 1'b1;
      end else begin
        ph_d  = PH_TYPE;
        bif_d = '0;
        asm_d = '0;
      end
    end

    if (fin_ent) begin
      ent_d = ent_q - 32'd1;
      if (ent_d == 32'd0) begin
        res[n[0]] = mk_res(KIND_OK, '0, '0, '0, '0, '0);
        n = n + 2'd1;
        ph_d = PH_SKIP;
      end else begin
        ph_d  = PH_ID;
        bif_d = '0;
        asm_d = '0;
      end
    end

    if (in_data_i.last_byte) begin
      if (ph_d != PH_SKIP) begin
        case (ph_d)
          PH_ID:    code = ERR_ID;
          PH_COUNT: code = ERR_COUNT;
          PH_DATA:  code = ERR_DATA;
          PH_TYPE:  code = ERR_COMP_HDR;
          PH_LEN:   code = ERR_COMP_HDR;
          default:  code = ERR_SHORT_HEADER;
        endcase
        res[n[0]] = mk_res(KIND_ERROR, '0, '0, '0, '0, code);
        n = n + 2'd1;
      end
      ph_d   = PH_HDR0;
      bif_d  = '0;
      asm_d  = '0;
      ent_d  = '0;
      comp_d = '0;
      dl_d   = '0;
      held_d = '0;
    end

    if (n != 2'd0) begin
      res[1'(n - 2'd1)].last_of_step = 1'b1;
    end

    push.count = accept ? n : 2'd0;
    push.r0    = res[0];
    push.r1    = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR0;
      bif_q  <= '0;
      asm_q  <= '0;
      ent_q  <= '0;
      comp_q <= '0;
      dl_q   <= '0;
      held_q <= '0;
    end else if (accept) begin
      ph_q   <= ph_d;
      bif_q  <= bif_d;
      asm_q  <= asm_d;
      ent_q  <= ent_d;
      comp_q <= comp_d;
      dl_q   <= dl_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= 32'd1;
      tomb_q    <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_EXPECTED_VERSION: exp_ver_q <= cfg_data_i;
        REG_TOMBSTONE_COUNT:  tomb_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  dssp_res_queue #(
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/dssp_snapshot_checker.sv
// result checker for the delta snapshot stream parser: tracks register writes,
// predicts the results of every accepted byte and compares them in order
// depends on dssp_pkg
module dssp_snapshot_checker #(
  parameter int unsigned ID_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  dssp_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  dssp_pkg::res_item_t            out_data_i,
  input  logic                           cfg_we_i,
  input  logic [dssp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatch_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dssp_pkg::*;

  localparam int unsigned REPORT_LIMIT = 40;

  // register copies
  logic [31:0] expected_version;
  logic [15:0] tombstone_count;

  // parser state
  phase_e      parse_phase;
  logic [5:0]  field_pos;
  logic [63:0] accum;
  logic [31:0] entities_left;
  logic [15:0] comps_left;
  logic [15:0] data_left;
  logic [15:0] held_word;

  res_item_t   step_results_q[$];
  res_item_t   parse_results_q[$];
  res_item_t   want;
  int unsigned mismatches = 0;

  task automatic add_result(input logic [2:0] kind, input logic [63:0] value,
                            input logic [2:0] hf, input logic [15:0] tid,
                            input logic [15:0] len, input logic [2:0] err);
    res_item_t r;
    r.kind         = kind;
    r.value        = value;
    r.header_field = hf;
    r.type_id      = tid;
    r.length       = len;
    r.error_code   = err;
    r.last_of_step = 1'b0;
    step_results_q = {step_results_q, r};
  endtask

  task automatic clear_parse();
    parse_phase   = PH_HDR0;
    field_pos     = '0;
    accum         = '0;
    entities_left = '0;
    comps_left    = '0;
    data_left     = '0;
    held_word     = '0;
  endtask

  task automatic open_field(input phase_e ph);
    parse_phase = ph;
    field_pos   = '0;
    accum       = '0;
  endtask

  task automatic end_entity();
    entities_left = entities_left - 1;
    if (entities_left == 0) begin
      add_result(KIND_OK, '0, '0, '0, '0, '0);
      parse_phase = PH_SKIP;
    end else begin
      open_field(PH_ID);
    end
  endtask

  task automatic end_component();
    comps_left = comps_left - 1;
    if (comps_left == 0) begin
      end_entity();
    end else begin
      open_field(PH_TYPE);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [5:0]  shift;
    int unsigned hdr_len;
    logic [2:0]  err;
    shift = {field_pos[2:0], 3'b000};
    case (parse_phase)
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: begin
        hdr_len = (parse_phase inside {PH_HDR0, PH_HDR4, PH_HDR5}) ? 4 : 8;
        accum = accum | (64'(b) << shift);
        field_pos = field_pos + 1;
        if (field_pos == hdr_len) begin
          add_result(KIND_HEADER, accum, parse_phase[2:0], '0, '0, '0);
          // data_left doubles as the version mismatch flag inside the header
          if (parse_phase == PH_HDR0) data_left = (accum[31:0] != expected_version) ? 16'd1 : 16'd0;
          if (parse_phase == PH_HDR4) entities_left = accum[31:0];
          if (parse_phase == PH_HDR5) begin
            if (data_left != 0) begin
              add_result(KIND_ERROR, '0, '0, '0, '0, ERR_VERSION);
              parse_phase = PH_SKIP;
            end else if (entities_left == 0) begin
              add_result(KIND_OK, '0, '0, '0, '0, '0);
              parse_phase = PH_SKIP;
            end else begin
              data_left = '0;
              open_field(PH_ID);
            end
          end else begin
            open_field(phase_e'(parse_phase + 1));
          end
        end
      end
      PH_ID: begin
        accum = accum | (64'(b) << shift);
        field_pos = field_pos + 1;
        if (field_pos >= ID_BYTES) begin
          parse_phase = PH_COUNT;
          field_pos   = '0;
          held_word   = '0;
        end
      end
      PH_COUNT: begin
        held_word = held_word | ((field_pos != 0) ? {b, 8'h00} : {8'h00, b});
        field_pos = field_pos + 1;
        if (field_pos >= 2) begin
          if (held_word == tombstone_count) begin
            add_result(KIND_TOMBSTONE, accum, '0, '0, held_word, '0);
            end_entity();
          end else begin
            add_result(KIND_ENTITY, accum, '0, '0, held_word, '0);
            comps_left = held_word;
            // an entity without components ends here
            if (comps_left == 0) begin
              comps_left = 16'd1;
              end_component();
            end else begin
              open_field(PH_TYPE);
            end
          end
        end
      end
      PH_TYPE: begin
        accum = accum | (64'(b) << shift);
        field_pos = field_pos + 1;
        if (field_pos >= 2) begin
          held_word = accum[15:0];
          open_field(PH_LEN);
        end
      end
      PH_LEN: begin
        accum = accum | (64'(b) << shift);
        field_pos = field_pos + 1;
        if (field_pos >= 2) begin
          data_left = accum[15:0];
          add_result(KIND_COMP_HDR, '0, '0, held_word, data_left, '0);
          if (data_left == 0) begin
            end_component();
          end else begin
            open_field(PH_DATA);
          end
        end
      end
      PH_DATA: begin
        add_result(KIND_DATA, 64'(b), '0, '0, '0, '0);
        data_left = data_left - 1;
        if (data_left == 0) end_component();
      end
      default: begin
      end
    endcase

    if (last) begin
      if (parse_phase != PH_SKIP) begin
        case (parse_phase)
          PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: err = ERR_SHORT_HEADER;
          PH_ID:    err = ERR_ID;
          PH_COUNT: err = ERR_COUNT;
          PH_DATA:  err = ERR_DATA;
          default:  err = ERR_COMP_HDR;
        endcase
        add_result(KIND_ERROR, '0, '0, '0, '0, err);
      end
      clear_parse();
    end

    if (step_results_q.size() > 0) begin
      step_results_q[step_results_q.size() - 1].last_of_step = 1'b1;
    end
    parse_results_q = {parse_results_q, step_results_q};
    step_results_q.delete();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_version = 32'd1;
      tombstone_count  = 16'hFFFF;
      clear_parse();
      parse_results_q.delete();
      step_results_q.delete();
      pending_o  <= 0;
      mismatch_o <= mismatches;
    end else begin
      // results first: none of them can stem from a byte taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (parse_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $error("result with nothing pending: kind %0d", out_data_i.kind);
          end
        end else begin
          want = parse_results_q.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_data_i.kind));
          check_field("value", want.value, out_data_i.value);
          check_field("header_field", 64'(want.header_field), 64'(out_data_i.header_field));
          check_field("type_id", 64'(want.type_id), 64'(out_data_i.type_id));
          check_field("length", 64'(want.length), 64'(out_data_i.length));
          check_field("error_code", 64'(want.error_code), 64'(out_data_i.error_code));
          check_field("last_of_step", 64'(want.last_of_step), 64'(out_data_i.last_of_step));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EXPECTED_VERSION: expected_version = cfg_data_i;
          REG_TOMBSTONE_COUNT:  tombstone_count  = cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) parse_byte(in_data_i.data_byte, in_data_i.last_byte);
      pending_o  <= parse_results_q.size();
      mismatch_o <= mismatches;
    end
  end

endmodule

// File: tb/sv/delta_snapshot_stream_parser_tb.sv
// testbench top of the delta snapshot stream parser: clock, reset, register
// writes, snapshot byte stimulus and the verdict
// depends on dssp_pkg, delta_snapshot_stream_parser and dssp_snapshot_checker
module delta_snapshot_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dssp_pkg::*;

  localparam int unsigned ID_BYTES      = 8;
  localparam int unsigned PHASE_BYTES   = 425;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned LONG_HOLD_AT  = 300;
  localparam int unsigned LONG_HOLD_LEN = 400;
  localparam int unsigned COUNT_OFFSET  = 28;

  typedef enum int {
    SNAP_GOOD,
    SNAP_BAD_VERSION,
    SNAP_CUT,
    SNAP_NOISE
  } snap_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  res_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int unsigned          outstanding;
  int unsigned          mismatches;

  logic [7:0]  snap_bytes[$];
  logic [31:0] cur_version   = 32'd1;
  logic [15:0] cur_tombstone = 16'hFFFF;
  int unsigned bytes_sent    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  delta_snapshot_stream_parser #(
    .ENTITY_ID_BYTES(ID_BYTES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  dssp_snapshot_checker #(
    .ID_BYTES(ID_BYTES)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pending_o  (outstanding),
    .mismatch_o (mismatches)
  );

  function automatic int unsigned byte_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] wide_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a clock edge; returns at the edge that takes the item
  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_le(input logic [63:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) snap_bytes = {snap_bytes, v[8*i +: 8]};
  endtask

  task automatic build_snapshot(input snap_kind_e kind);
    logic [31:0] version;
    logic [15:0] count;
    int unsigned n_ent;
    int unsigned n_data;
    int unsigned cut;
    snap_bytes.delete();
    if (kind == SNAP_NOISE) begin
      repeat ($urandom_range(1, 5)) snap_bytes = {snap_bytes, 8'($urandom)};
      return;
    end
    version = cur_version;
    if (kind == SNAP_BAD_VERSION) begin
      if ($urandom_range(0, 1) == 0) version = ~cur_version;
      else version = cur_version ^ (32'd1 << $urandom_range(0, 31));
    end
    n_ent = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    push_le(64'(version), 4);
    push_le(wide_value(), 8);
    push_le(wide_value(), 8);
    push_le(wide_value(), 8);
    push_le(64'(n_ent), 4);
    push_le(wide_value(), 4);
    repeat (n_ent) begin
      push_le(wide_value(), ID_BYTES);
      count = ($urandom_range(0, 5) == 0) ? cur_tombstone : 16'($urandom_range(0, 3));
      push_le(64'(count), 2);
      if (count != cur_tombstone) begin
        repeat (count) begin
          push_le(64'($urandom), 2);
          n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
          push_le(64'(n_data), 2);
          repeat (n_data) snap_bytes = {snap_bytes, 8'($urandom)};
        end
      end
    end
    if (kind == SNAP_CUT) begin
      // sometimes overwrite the entity count with a random value
      if ($urandom_range(0, 3) == 0) begin
        for (int i = COUNT_OFFSET; i < COUNT_OFFSET + 4; i++) snap_bytes[i] = 8'($urandom);
      end
      cut = $urandom_range(1, snap_bytes.size());
      while (snap_bytes.size() > cut) void'(snap_bytes.pop_back());
    end else if (kind == SNAP_GOOD) begin
      repeat ($urandom_range(0, 3)) snap_bytes = {snap_bytes, 8'($urandom)};
    end
  endtask

  task automatic send_snapshot();
    logic burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (snap_bytes[i]) begin
      send_byte(snap_bytes[i], i == snap_bytes.size() - 1, burst ? 0 : byte_gap());
    end
    bytes_sent += snap_bytes.size();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // bytes that give no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] version, input logic [15:0] tombstone);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EXPECTED_VERSION;
    cfg_data  <= version;
    @(posedge clk);
    cfg_index <= REG_TOMBSTONE_COUNT;
    cfg_data  <= {16'h0000, tombstone};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_version   = version;
    cur_tombstone = tombstone;
  endtask

  task automatic run_phase(input logic [31:0] version, input logic [15:0] tombstone);
    int unsigned start;
    int unsigned n;
    int unsigned r;
    snap_kind_e  kind;
    set_config(version, tombstone);
    start = bytes_sent;
    n     = 0;
    while (bytes_sent - start < PHASE_BYTES) begin
      if (n < 4) begin
        kind = snap_kind_e'(n);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) kind = SNAP_GOOD;
        else if (r < 80) kind = SNAP_CUT;
        else if (r < 90) kind = SNAP_BAD_VERSION;
        else kind = SNAP_NOISE;
      end
      build_snapshot(kind);
      send_snapshot();
      n++;
    end
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_EXPECTED_VERSION;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // lone bytes under the reset settings: short headers at both extremes
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'hA5, 1'b0, 0);
    send_byte(8'h5A, 1'b1, 2);
    wait_idle();

    run_phase(32'd1, 16'hFFFF);
    run_phase(32'd0, 16'h0000);
    run_phase(32'hFFFF_FFFF, 16'($urandom_range(1, 3)));
    run_phase($urandom, 16'($urandom));

    if (mismatches == 0 && outstanding == 0) begin
      $display("delta_snapshot_stream_parser_tb OK");
    end else begin
      $display("delta_snapshot_stream_parser_tb NOT OK");
    end
    $finish;
  end

  // result side: random stalls, and one long hold so that the block backs up
  initial begin
    int unsigned hold;
    int unsigned span;
    int unsigned rx_cycles;
    int unsigned r;
    logic        long_hold_done;
    rx_cycles      = 0;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && rx_cycles >= LONG_HOLD_AT) begin
        hold           = LONG_HOLD_LEN;
        long_hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) hold = 0;
        else if (r < 88) hold = $urandom_range(1, 3);
        else if (r < 97) hold = $urandom_range(4, 12);
        else hold = $urandom_range(20, 60);
      end
      out_ready <= (hold == 0);
      span = (hold == 0) ? $urandom_range(1, 16) : hold;
      repeat (span) begin
        @(posedge clk);
        rx_cycles++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("delta_snapshot_stream_parser_tb NOT OK");
    $finish;
  end

endmodule
